@@ rtl/dq_pkg.sv @@
package dq_pkg;

    localparam int DQ_DEPTH   = 16;
    localparam int CMDQ_DEPTH = 2;
    localparam int VALUE_W    = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_BWD   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_LIST
    } t_back_state;

    typedef struct packed {
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic listing;
        logic take;
    } t_back_stat;

endpackage

@@ rtl/double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit values held in a ring of DEPTH
// entries. Raise i_start with i_mode and i_item_value while o_busy is low to
// issue a request. A push or pop gives one result, registered in the back
// end, once taken; requests can be issued every cycle while no listing runs.
// A listing gives one result per stored entry, one per cycle, with o_last on
// the final one; the store has a single read port, so a listing occupies the
// execution side until its final entry while up to QDEPTH further requests
// queue behind it. Results appear for exactly one cycle on o_valid and
// cannot be held off. Modes six and seven are taken and ignored.
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH  = DQ_DEPTH,
    parameter int QDEPTH = CMDQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [2:0]                 i_mode,
    input  logic signed [VALUE_W-1:0]  i_item_value,
    output logic                       o_valid,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic [1:0]                 o_status,
    output logic                       o_last
);

    logic       w_cmd_valid;
    t_cmd       w_cmd;
    t_back_stat w_bstat;

    dq_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_mode       (i_mode),
        .i_item_value (i_item_value),
        .o_busy       (o_busy),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_bstat.take)
    );

    dq_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_stat      (w_bstat),
        .o_valid     (o_valid),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_cmd_valid && !w_bstat.listing) |=> !o_valid)
        else $error("result without a pending request");

    a_list_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && o_status == ST_OK))
        else $error("listing interrupted");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_last && o_out_value == '0))
        else $error("error result not final or carries data");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.take |-> (w_cmd_valid && !w_bstat.listing))
        else $error("request taken while listing or queue empty");

endmodule

@@ rtl/dq_front.sv @@
module dq_front import dq_pkg::*; #(
    parameter int QDEPTH = CMDQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2:0]                 i_mode,
    input  logic signed [VALUE_W-1:0]  i_item_value,
    output logic                       o_busy,
    output logic                       o_cmd_valid,
    output t_cmd                       o_cmd,
    input  logic                       i_cmd_take
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_cmd             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             push;
    logic             mode_ok;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // modes six and seven are dropped here: no result, no state change
    assign mode_ok = i_mode inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT,
                                    OP_POP_BACK, OP_LIST_FWD, OP_LIST_BWD};

    assign o_busy      = (r_cnt == QCW'(QDEPTH));
    assign push        = i_start && !o_busy && mode_ok;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ptr_inc(r_wp) : r_wp;
        n_rp  = i_cmd_take ? ptr_inc(r_rp) : r_rp;
        n_cnt = r_cnt + QCW'(push) - QCW'(i_cmd_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: t_op'(i_mode), value: i_item_value};
        end
    end

endmodule

@@ rtl/dq_back.sv @@
module dq_back import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  t_cmd                       i_cmd,
    output t_back_stat                 o_stat,
    output logic                       o_valid,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic [1:0]                 o_status,
    output logic                       o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    t_back_state        r_state, n_state;
    logic [AW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_bwd, n_bwd;

    logic               r_p_valid, n_p_valid;
    t_status            r_p_status, n_p_status;
    logic               r_p_last, n_p_last;
    logic               r_p_use, n_p_use;

    logic               take;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      list_off;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign take     = i_cmd_valid && (r_state == BK_IDLE);
    assign cnt_m1   = r_count - 1'b1;
    assign list_off = r_bwd ? (cnt_m1 - r_idx) : r_idx;

    assign o_stat = '{listing: (r_state == BK_LIST), take: take};

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_bwd      = r_bwd;
        n_p_valid  = 1'b0;
        n_p_status = ST_OK;
        n_p_last   = 1'b1;
        n_p_use    = 1'b0;
        we         = 1'b0;
        wr_addr    = r_front;
        rd_addr    = r_front;

        case (r_state)
            BK_IDLE: begin
                if (take) begin
                    n_p_valid = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_p_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_cmd.op == OP_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? AW'(DEPTH - 1)
                                                              : r_front - 1'b1;
                                    wr_addr = n_front;
                                end else begin
                                    wr_addr = slot(r_front, r_count[AW-1:0]);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_p_status = ST_EMPTY;
                            end else begin
                                n_p_use = 1'b1;
                                n_count = cnt_m1;
                                if (i_cmd.op == OP_POP_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = slot(r_front, AW'(1));
                                end else begin
                                    rd_addr = slot(r_front, cnt_m1[AW-1:0]);
                                end
                            end
                        end
                        OP_LIST_FWD, OP_LIST_BWD: begin
                            if (r_count == '0) begin
                                n_p_status = ST_EMPTY;
                            end else begin
                                n_p_use = 1'b1;
                                n_bwd   = (i_cmd.op == OP_LIST_BWD);
                                rd_addr = n_bwd ? slot(r_front, cnt_m1[AW-1:0])
                                                : r_front;
                                n_p_last = (r_count == CW'(1));
                                if (!n_p_last) begin
                                    n_state = BK_LIST;
                                    n_idx   = CW'(1);
                                end
                            end
                        end
                        default: begin
                            n_p_valid = 1'b0;
                        end
                    endcase
                end
            end
            BK_LIST: begin
                // one entry per cycle through the single read port
                n_p_valid = 1'b1;
                n_p_use   = 1'b1;
                rd_addr   = slot(r_front, list_off[AW-1:0]);
                n_p_last  = (r_idx == cnt_m1);
                if (n_p_last) begin
                    n_state = BK_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_bwd     <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_bwd     <= n_bwd;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_status <= n_p_status;
        r_p_last   <= n_p_last;
        r_p_use    <= n_p_use;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid     = r_p_valid;
    assign o_out_value = r_p_use ? r_rd_data : '0;
    assign o_status    = r_p_status;
    assign o_last      = r_p_last;

endmodule
